>>> rtl/mbfr_pkg.sv
`default_nettype none

package mbfr_pkg;

   // command codes on req_cmd
   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_READ    = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_ALIGN   = 3'd3,
      CMD_RESTART = 3'd4
   } cmd_type;

   // status codes on rsp_status
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NEED_MORE  = 3'd1,
      ST_OVERFLOW   = 3'd2,
      ST_BAD_LENGTH = 3'd3,
      ST_QUEUE_FULL = 3'd4
   } status_type;

   localparam logic [5:0] MAX_FIELD_BITS = 6'd32;
   localparam int         WINDOW_BYTES   = 5;
   localparam int         WINDOW_BITS    = WINDOW_BYTES * 8;
   localparam int         NBR_SPAN       = 4;

   // per-cycle move applied to every byte cell
   typedef struct packed {
      logic       shift_en;
      logic [2:0] shift_bytes;
   } cell_ctrl_type;

   typedef struct packed {
      logic [31:0] field_value;
      status_type  status;
      logic [7:0]  bits_available;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/mbfr_cell.sv
`default_nettype none

module mbfr_cell
   import mbfr_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          load_en,
   input  wire logic [7:0]    load_byte,
   input  wire logic [7:0]    nbr_byte [1:NBR_SPAN],
   output      logic [7:0]    cell_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (load_en) begin
         byte_in = load_byte;
      end else if (ctrl.shift_en) begin
         case (ctrl.shift_bytes)
            3'd1:    byte_in = nbr_byte[1];
            3'd2:    byte_in = nbr_byte[2];
            3'd3:    byte_in = nbr_byte[3];
            3'd4:    byte_in = nbr_byte[4];
            default: byte_in = byte_ff;
         endcase
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

`default_nettype wire

>>> rtl/mbfr_out_buf.sv
`default_nettype none

module mbfr_out_buf
   import mbfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output      logic       in_stall,
   input  wire result_type in_result,
   output      logic       out_valid,
   input  wire logic       out_stall,
   output      result_type out_result
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       take;
   logic       acc;

   assign take = out_valid_ff && !out_stall;
   assign acc  = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = acc;
            if (acc) begin
               out_in = in_result;
            end
         end
      end else if (acc) begin
         skid_in       = in_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_stall   = skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

`default_nettype wire

>>> rtl/msb_first_bit_field_reader_core.sv
// msb-first bit field reader over a bounded byte queue
//
// req channel: one command per item (push byte, read field, peek field,
// align to byte, restart), accepted when req_valid is high and req_stall low
// rsp channel: exactly one result item per request item, in order, with the
// field value, a status code and the unread bit count after the command
// results are registered; throughput: one item per cycle while req_stall
// is low; the byte cells move by up to four places in the cycle an item is
// accepted, so the next item sees the new queue
// a push lands in the first free cell; reads take a five-byte window from
// the head cells and shift the whole row forward by the bytes consumed
// reset (and the restart command) empties the queue and clears the sticky
// overflow and end marks; no clearing pass, cell contents are left as is
// when the receiver stalls, the output register holds its item and a skid
// stage takes one more; req_stall then rises until the skid stage drains

`default_nettype none

module msb_first_bit_field_reader_core
   import mbfr_pkg::*;
#(
   parameter int QUEUE_BYTES = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [5:0]  req_bit_count,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_field_value,
   output      logic [2:0]  rsp_status,
   output      logic [7:0]  rsp_bits_available
);

   localparam int CNT_W  = $clog2(QUEUE_BYTES + 1);
   localparam int HELD_W = CNT_W + 3;

   // queue occupancy in cells (a partly read head byte still counts)
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   // bit offset of the next unread bit inside the head cell
   logic [2:0]       off_ff, off_in;
   logic             ovf_ff, ovf_in;
   logic             end_ff, end_in;

   logic             accept;
   logic             push_ok;
   cell_ctrl_type    ctrl;
   logic [7:0]       cell_q [QUEUE_BYTES];

   logic [HELD_W-1:0]      held;
   logic [HELD_W-1:0]      held_next;
   logic [HELD_W+7:0]      held_next_ext;
   logic [HELD_W-1:0]      need_bits;
   logic [WINDOW_BITS-1:0] window;
   logic [WINDOW_BITS-1:0] window_aligned;
   logic [WINDOW_BITS-1:0] field_wide;
   logic [5:0]             bit_sum;
   logic [31:0]            value;
   status_type             status;
   result_type             result;

   assign accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // head window and field extraction
   // ---------------------------------------------------------------
   assign held      = {cnt_ff, 3'b000} - HELD_W'(off_ff);
   assign need_bits = HELD_W'(req_bit_count);
   assign window    = {cell_q[0], cell_q[1], cell_q[2], cell_q[3], cell_q[4]};

   // first unread bit moved to the top, then the field right aligned
   assign window_aligned = window << off_ff;
   assign field_wide     = window_aligned >> (6'(WINDOW_BITS) - req_bit_count);
   assign bit_sum        = {3'b000, off_ff} + req_bit_count;

   // ---------------------------------------------------------------
   // command decode and next state
   // ---------------------------------------------------------------
   always_comb begin
      cnt_in           = cnt_ff;
      off_in           = off_ff;
      ovf_in           = ovf_ff;
      end_in           = end_ff;
      ctrl.shift_en    = 1'b0;
      ctrl.shift_bytes = 3'd0;
      push_ok          = 1'b0;
      value            = '0;
      status           = ST_OK;
      unique case (req_cmd)
         CMD_PUSH: begin
            if (cnt_ff == CNT_W'(QUEUE_BYTES)) begin
               status = ST_QUEUE_FULL;
            end else begin
               push_ok = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
               if (req_last_byte) begin
                  end_in = 1'b1;
               end
            end
         end
         CMD_READ, CMD_PEEK: begin
            if (req_bit_count > MAX_FIELD_BITS) begin
               status = ST_BAD_LENGTH;
            end else if (req_bit_count == 6'd0) begin
               status = ST_OK;
            end else if (ovf_ff) begin
               status = ST_OVERFLOW;
            end else if (held < need_bits) begin
               // short field: fatal once the stream end has been pushed
               if (end_ff) begin
                  status = ST_OVERFLOW;
                  if (req_cmd == CMD_READ) begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  status = ST_NEED_MORE;
               end
            end else begin
               value = field_wide[31:0];
               if (req_cmd == CMD_READ) begin
                  ctrl.shift_en    = 1'b1;
                  ctrl.shift_bytes = bit_sum[5:3];
                  cnt_in           = cnt_ff - CNT_W'(bit_sum[5:3]);
                  off_in           = bit_sum[2:0];
               end
            end
         end
         CMD_ALIGN: begin
            // drop the unread rest of a partly read head byte
            if (off_ff != 3'd0) begin
               ctrl.shift_en    = 1'b1;
               ctrl.shift_bytes = 3'd1;
               cnt_in           = cnt_ff - CNT_W'(1);
               off_in           = 3'd0;
            end
         end
         CMD_RESTART: begin
            cnt_in = '0;
            off_in = 3'd0;
            ovf_in = 1'b0;
            end_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign held_next     = {cnt_in, 3'b000} - HELD_W'(off_in);
   assign held_next_ext = {8'd0, held_next};

   assign result.field_value    = value;
   assign result.status         = status;
   assign result.bits_available = held_next_ext[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         off_ff <= 3'd0;
         ovf_ff <= 1'b0;
         end_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         off_ff <= off_in;
         ovf_ff <= ovf_in;
         end_ff <= end_in;
      end
   end

   // ---------------------------------------------------------------
   // row of byte cells, head at index 0
   // ---------------------------------------------------------------
   cell_ctrl_type cell_ctrl;

   always_comb begin
      cell_ctrl          = ctrl;
      cell_ctrl.shift_en = ctrl.shift_en && accept;
   end

   for (genvar i = 0; i < QUEUE_BYTES; i++) begin : g_cell
      logic [7:0] nbr [1:NBR_SPAN];
      logic       load_en;

      for (genvar j = 1; j <= NBR_SPAN; j++) begin : g_nbr
         if (i + j < QUEUE_BYTES) begin : g_in_row
            assign nbr[j] = cell_q[i + j];
         end else begin : g_past_end
            assign nbr[j] = 8'd0;
         end
      end

      assign load_en = accept && push_ok && (cnt_ff == CNT_W'(i));

      mbfr_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .load_en   (load_en),
         .load_byte (req_data_byte),
         .nbr_byte  (nbr),
         .cell_byte (cell_q[i])
      );
   end

   // ---------------------------------------------------------------
   // output register with skid stage
   // ---------------------------------------------------------------
   result_type rsp_result;

   mbfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_stall   (req_stall),
      .in_result  (result),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (rsp_result)
   );

   assign rsp_field_value    = rsp_result.field_value;
   assign rsp_status         = rsp_result.status;
   assign rsp_bits_available = rsp_result.bits_available;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_BYTES))
      else $error("queue occupancy beyond capacity");

   a_off_needs_byte: assert property (@(posedge clock) disable iff (reset)
      (off_ff != 3'd0) |-> (cnt_ff != '0))
      else $error("bit offset set on an empty queue");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while output register is empty");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_RESTART)) |=>
         ((cnt_ff == '0) && (off_ff == 3'd0) && !ovf_ff && !end_ff))
      else $error("restart left state behind");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && !$past(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("accepted item produced no result");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import mbfr_pkg::*;

   localparam int STORE_BYTES = 16;
   localparam int RANDOM_TARGET = 1400;

   // one request item as queued for the driver
   typedef struct {
      logic [2:0] cmd;
      logic [7:0] data;
      logic       last;
      logic [5:0] count;
      bit         drain_first;   // hold back until every result is in
   } field_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_PUSH;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic [5:0]  req_bit_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_field_value;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_bits_available;

   field_req_type pending_reqs[$];
   result_type  fields_due[$];
   int          mismatch_count = 0;
   int          accepted_reqs = 0;
   bit          req_went = 1'b0;

   // shadow of the reader state
   logic [7:0]  shadow_bytes [STORE_BYTES];
   logic [3:0]  shadow_wr_slot = '0;
   logic [6:0]  shadow_rd_pos = '0;
   int unsigned shadow_held = 0;
   bit          shadow_overflow = 1'b0;
   bit          shadow_end = 1'b0;

   msb_first_bit_field_reader_core #(
      .QUEUE_BYTES(STORE_BYTES)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_bit_count      (req_bit_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_field_value    (rsp_field_value),
      .rsp_status         (rsp_status),
      .rsp_bits_available (rsp_bits_available)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic add_req(input logic [2:0] cmd, input logic [7:0] data,
                          input logic last, input logic [5:0] count);
      field_req_type r;
      r.cmd = cmd;
      r.data = data;
      r.last = last;
      r.count = count;
      r.drain_first = 1'b0;
      pending_reqs.push_back(r);
   endtask

   // one random item; mode 0 fills the queue, 1 drains it, 2 mixes
   task automatic add_random_req(input int mode);
      int roll;
      int push_pct;
      int read_pct;
      int len_roll;
      field_req_type r;
      roll = $urandom_range(0, 99);
      push_pct = (mode == 0) ? 70 : (mode == 1) ? 22 : 42;
      read_pct = (mode == 0) ? 14 : (mode == 1) ? 50 : 32;
      r.data = 8'($urandom);
      r.last = 1'($urandom);
      r.drain_first = 1'b0;
      len_roll = $urandom_range(0, 19);
      if (len_roll == 0)
         r.count = '0;
      else if (len_roll == 1)
         r.count = 6'($urandom_range(33, 63));
      else if (len_roll < 6)
         r.count = 6'($urandom_range(1, 8));
      else if (len_roll == 6)
         r.count = MAX_FIELD_BITS;
      else
         r.count = 6'($urandom_range(1, 32));
      if (roll < push_pct) begin
         r.cmd = CMD_PUSH;
         r.last = ($urandom_range(0, 39) == 0);
      end else if (roll < push_pct + read_pct) begin
         r.cmd = CMD_READ;
      end else if (roll < 90) begin
         r.cmd = CMD_PEEK;
      end else if (roll < 95) begin
         r.cmd = CMD_ALIGN;
      end else if (roll < 97) begin
         r.cmd = CMD_RESTART;
      end else begin
         r.cmd = 3'($urandom_range(5, 7));   // codes with no meaning
      end
      pending_reqs.push_back(r);
   endtask

   // gather n bits msb first from the shadow queue, starting at pos
   function automatic logic [31:0] gather_bits(input logic [6:0] pos, input int n);
      logic [31:0] acc;
      logic [6:0]  p;
      acc = '0;
      p = pos;
      for (int k = 0; k < n; k++) begin
         acc = {acc[30:0], shadow_bytes[p[6:3]][3'd7 - p[2:0]]};
         p++;   // seven bits wrap at the end of the store
      end
      return acc;
   endfunction

   // apply one accepted request to the shadow state and queue its result
   task automatic predict_field(input logic [2:0] cmd, input logic [7:0] data,
                                input logic last, input logic [5:0] count);
      result_type  res;
      int unsigned drop;
      res.field_value = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (((shadow_held + 7) >> 3) >= STORE_BYTES) begin
               res.status = ST_QUEUE_FULL;
            end else begin
               shadow_bytes[shadow_wr_slot] = data;
               shadow_wr_slot++;
               shadow_held += 8;
               if (last)
                  shadow_end = 1'b1;
            end
         end
         CMD_READ, CMD_PEEK: begin
            if (count > MAX_FIELD_BITS) begin
               res.status = ST_BAD_LENGTH;
            end else if (count == 0) begin
               res.status = ST_OK;
            end else if (shadow_overflow) begin
               res.status = ST_OVERFLOW;
            end else if (shadow_held < count) begin
               if (shadow_end) begin
                  res.status = ST_OVERFLOW;
                  if (cmd == CMD_READ)
                     shadow_overflow = 1'b1;
               end else begin
                  res.status = ST_NEED_MORE;
               end
            end else begin
               res.field_value = gather_bits(shadow_rd_pos, int'(count));
               if (cmd == CMD_READ) begin
                  shadow_rd_pos = shadow_rd_pos + 7'(count);
                  shadow_held -= count;
               end
            end
         end
         CMD_ALIGN: begin
            if (shadow_rd_pos[2:0] != 3'd0) begin
               drop = 8 - shadow_rd_pos[2:0];
               shadow_held = (shadow_held >= drop) ? shadow_held - drop : 0;
               shadow_rd_pos = shadow_rd_pos + 7'(drop);
            end
         end
         CMD_RESTART: begin
            shadow_wr_slot = '0;
            shadow_rd_pos = '0;
            shadow_held = 0;
            shadow_overflow = 1'b0;
            shadow_end = 1'b0;
         end
         default: begin
         end
      endcase
      res.bits_available = shadow_held[7:0];
      fields_due.push_back(res);
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      result_type due;
      req_went = 1'b0;
      if (!reset) begin
         // compare the result first; its item was accepted at an earlier edge
         if (rsp_valid && !rsp_stall) begin
            if (fields_due.size() == 0) begin
               report_mismatch("result item with none expected");
            end else begin
               due = fields_due.pop_front();
               if (rsp_field_value !== due.field_value)
                  report_mismatch($sformatf("field_value %h, expected %h",
                                            rsp_field_value, due.field_value));
               if (rsp_status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, due.status));
               if (rsp_bits_available !== due.bits_available)
                  report_mismatch($sformatf("bits_available %0d, expected %0d",
                                            rsp_bits_available, due.bits_available));
            end
         end
         if (req_valid && !req_stall) begin
            predict_field(req_cmd, req_data_byte, req_last_byte, req_bit_count);
            accepted_reqs++;
            req_went = 1'b1;
         end
      end
   end

   // request driver, fed from the pending queue
   int send_gap = 0;

   always @(negedge clock) begin
      field_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_went) begin
         // a stalled item stays on the bus untouched, so we only get here when free
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_reqs[0].drain_first && fields_due.size() != 0) begin
            req_valid <= 1'b0;   // pause until the block has emptied
         end else if (pending_reqs.size() >= 200 && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else begin
            nxt = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_cmd <= nxt.cmd;
            req_data_byte <= nxt.data;
            req_last_byte <= nxt.last;
            req_bit_count <= nxt.count;
         end
      end
   end

   // receiver back-pressure, with one long hold-off to fill the block
   int  rsp_hold_left = 0;
   bit  long_hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!long_hold_done && accepted_reqs >= 500) begin
            long_hold_done = 1'b1;
            rsp_hold_left = 60;
         end else if (rsp_hold_left == 0 && pending_reqs.size() >= 200 &&
                      $urandom_range(0, 7) == 0) begin
            rsp_hold_left = $urandom_range(1, 9);
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int mode;
      int seg_len;
      int directed_len;

      // directed: empty reads, odd lengths, align, end mark, sticky overflow
      add_req(CMD_READ,  8'h00, 1'b0, 6'd8);    // nothing held yet
      add_req(CMD_PEEK,  8'h00, 1'b0, 6'd1);
      add_req(CMD_PUSH,  8'hA5, 1'b0, 6'd0);
      add_req(CMD_PUSH,  8'h3C, 1'b0, 6'd63);
      add_req(CMD_READ,  8'hFF, 1'b1, 6'd0);    // zero length
      add_req(CMD_READ,  8'h00, 1'b0, 6'd33);   // just over the limit
      add_req(CMD_PEEK,  8'h00, 1'b0, 6'd63);
      add_req(CMD_READ,  8'h00, 1'b0, 6'd3);
      add_req(CMD_PEEK,  8'h00, 1'b0, 6'd13);
      add_req(CMD_ALIGN, 8'h00, 1'b0, 6'd0);    // drops the rest of a byte
      add_req(CMD_ALIGN, 8'hFF, 1'b1, 6'd63);   // already on a boundary
      add_req(CMD_READ,  8'h00, 1'b0, 6'd8);
      add_req(CMD_PUSH,  8'hFF, 1'b1, 6'd0);    // final byte
      add_req(CMD_PUSH,  8'h00, 1'b0, 6'd0);    // push after the end mark
      add_req(CMD_READ,  8'h00, 1'b0, 6'd32);   // short after end
      add_req(CMD_PEEK,  8'h00, 1'b0, 6'd4);    // overflow now sticky
      add_req(CMD_READ,  8'h00, 1'b0, 6'd5);
      add_req(CMD_PEEK,  8'h00, 1'b0, 6'd0);    // zero length ignores overflow
      add_req(3'd5,      8'hFF, 1'b1, 6'd63);
      add_req(3'd6,      8'hFF, 1'b1, 6'd63);
      add_req(3'd7,      8'hFF, 1'b1, 6'd63);
      add_req(CMD_RESTART, 8'h00, 1'b0, 6'd0);
      add_req(CMD_PUSH,  8'h5A, 1'b0, 6'd0);
      add_req(CMD_PEEK,  8'h00, 1'b0, 6'd16);   // short before end
      add_req(CMD_PUSH,  8'hC3, 1'b1, 6'd0);
      add_req(CMD_READ,  8'h00, 1'b0, 6'd16);
      add_req(CMD_PEEK,  8'h00, 1'b0, 6'd1);    // short peek after end
      directed_len = pending_reqs.size();

      // random segments, each possibly opened by a restart
      while (pending_reqs.size() < directed_len + RANDOM_TARGET) begin
         mode = $urandom_range(0, 2);
         seg_len = $urandom_range(20, 80);
         if ($urandom_range(0, 1) == 1)
            add_req(CMD_RESTART, 8'($urandom), 1'($urandom), 6'($urandom));
         repeat (seg_len) add_random_req(mode);
      end
      pending_reqs[700].drain_first = 1'b1;
      pending_reqs[1100].drain_first = 1'b1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(negedge clock);
      while (fields_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fields_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", fields_due.size()));

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
